// ===== rtl/core/mpd_pkg.sv =====
// shared types and constants of the masked patch distance block
package mpd_pkg;

	localparam int PIX_W   = 24;
	localparam int CHAN_W  = 8;
	localparam int MASK_W  = 8;
	localparam int PW_W    = 4;
	localparam int SQ_W    = 2 * CHAN_W;
	localparam int SUM_W   = 26;
	localparam int CNT_W   = 8;
	localparam int STEP_W  = 5;

	localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
	localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);

	// configuration register indexes
	localparam logic REG_PATCH_WIDTH = 1'b0;
	localparam logic REG_MASK_LIMIT  = 1'b1;

	localparam logic [PW_W-1:0]   PATCH_WIDTH_RST = 4'd7;
	localparam logic [MASK_W-1:0] MASK_LIMIT_RST  = 8'd10;

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_DRAIN,
		ST_DECIDE,
		ST_DIV,
		ST_OUTWAIT
	} state_t;

	typedef struct packed {
		logic s1_load;
		logic decide;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic rej;
		logic div_last;
		logic out_free;
	} status_t;

	function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

// ===== rtl/core/mpd_ctrl.sv =====
// sequencer for accumulation, decision, division and result hand-off
module mpd_ctrl import mpd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_last_flag,
	input  status_t stat,
	output logic    in_ready,
	output cmd_t    cmd
);

	state_t state_q, state_nxt;
	logic   accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_ACCUM: begin
				if (accept && in_last_flag) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_nxt = stat.rej ? ST_OUTWAIT : ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_last) begin
					state_nxt = ST_OUTWAIT;
				end
			end
			ST_OUTWAIT: begin
				if (stat.out_free) begin
					state_nxt = ST_ACCUM;
				end
			end
			default: begin
				state_nxt = ST_ACCUM;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			ST_ACCUM: begin
				in_ready    = 1'b1;
				cmd.s1_load = in_valid;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_OUTWAIT: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/core/mpd_dp.sv =====
// datapath: config registers, square stage, accumulators, divider, output register
module mpd_dp import mpd_pkg::*; #(
	parameter int MAX_PATCH_WIDTH = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [MASK_W-1:0] cfg_data,
	input  logic [PIX_W-1:0]  a_pixel,
	input  logic [PIX_W-1:0]  b_pixel,
	input  logic [MASK_W-1:0] a_mask,
	input  logic [MASK_W-1:0] b_mask,
	input  logic              center_flag,
	input  logic [PIX_W-1:0]  cutoff,
	input  cmd_t              cmd,
	output status_t           stat,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [PIX_W-1:0]  distance,
	output logic              rejected
);

	localparam logic [PW_W-1:0] PW_CLAMP = PW_W'(MAX_PATCH_WIDTH);

	logic [PW_W-1:0]   patch_width_q;
	logic [MASK_W-1:0] mask_limit_q;

	// stage 1: squared channel differences of the accepted word
	logic [SQ_W-1:0]  sq_r_s1, sq_g_s1, sq_b_s1;
	logic             pair_ok_s1, center_hit_s1, valid_s1;
	logic [PIX_W-1:0] cutoff_s1;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic             center_masked_q;

	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q, divisor_q;
	logic [STEP_W-1:0] step_q;
	logic              rej_q;

	logic              out_valid_q, rejected_q;
	logic [PIX_W-1:0]  distance_q;

	logic [CHAN_W-1:0] d_r, d_g, d_b;
	logic [SQ_W+1:0]   sq_tot;
	logic [SUM_W:0]    sum_ext;
	logic [PW_W-1:0]   w_eff;
	logic [2*PW_W-1:0] w_sq;
	logic [CNT_W+1:0]  cnt_x3;
	logic              rej;
	logic [CNT_W:0]    trial;
	logic              trial_ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			patch_width_q <= PATCH_WIDTH_RST;
			mask_limit_q  <= MASK_LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_PATCH_WIDTH) begin
				patch_width_q <= cfg_data[PW_W-1:0];
			end else begin
				mask_limit_q <= cfg_data;
			end
		end
	end

	assign d_r = abs_diff(a_pixel[7:0], b_pixel[7:0]);
	assign d_g = abs_diff(a_pixel[15:8], b_pixel[15:8]);
	assign d_b = abs_diff(a_pixel[23:16], b_pixel[23:16]);

	always_ff @(posedge clk) begin
		if (cmd.s1_load) begin
			sq_r_s1       <= SQ_W'(d_r) * SQ_W'(d_r);
			sq_g_s1       <= SQ_W'(d_g) * SQ_W'(d_g);
			sq_b_s1       <= SQ_W'(d_b) * SQ_W'(d_b);
			pair_ok_s1    <= (a_mask < mask_limit_q) && (b_mask < mask_limit_q);
			center_hit_s1 <= center_flag && (b_mask > mask_limit_q);
			cutoff_s1     <= cutoff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.s1_load;
		end
	end

	assign sq_tot  = (SQ_W+2)'(sq_r_s1) + (SQ_W+2)'(sq_g_s1) + (SQ_W+2)'(sq_b_s1);
	assign sum_ext = {1'b0, sum_q} + (SUM_W+1)'(sq_tot);

	// accumulators, cleared when the patch is handed to the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q           <= '0;
			cnt_q           <= '0;
			center_masked_q <= 1'b0;
		end else if (cmd.decide) begin
			sum_q           <= '0;
			cnt_q           <= '0;
			center_masked_q <= 1'b0;
		end else if (valid_s1) begin
			if (center_hit_s1) begin
				center_masked_q <= 1'b1;
			end
			if (pair_ok_s1) begin
				sum_q <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
				if (cnt_q != CNT_MAX) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// size test and center test
	assign w_eff  = (patch_width_q > PW_CLAMP) ? PW_CLAMP : patch_width_q;
	assign w_sq   = (2*PW_W)'(w_eff) * (2*PW_W)'(w_eff);
	assign cnt_x3 = (CNT_W+2)'({cnt_q, 1'b0}) + (CNT_W+2)'(cnt_q);
	assign rej    = center_masked_q || (cnt_q == '0) || (cnt_x3 < (CNT_W+2)'(w_sq));

	// restoring divider, one quotient bit per cycle
	assign trial    = {rem_q, quo_q[SUM_W-1]};
	assign trial_ge = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			quo_q     <= sum_q;
			rem_q     <= '0;
			divisor_q <= cnt_q;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SUM_W-2:0], trial_ge};
			rem_q <= trial_ge ? CNT_W'(trial - {1'b0, divisor_q}) : trial[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			rej_q  <= 1'b0;
		end else if (cmd.decide) begin
			step_q <= '0;
			rej_q  <= rej;
		end else if (cmd.div_step) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			distance_q <= rej_q ? cutoff_s1 : quo_q[PIX_W-1:0];
			rejected_q <= rej_q;
		end
	end

	assign stat.rej      = rej;
	assign stat.div_last = step_q == DIV_LAST;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign distance  = distance_q;
	assign rejected  = rejected_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken word");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (step_q <= DIV_LAST))
		else $error("divider ran past its last step");

	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |-> (!valid_s1 && !cmd.s1_load))
		else $error("accumulators cleared with a word in flight");

	a_accept_stops: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |=> !cmd.decide)
		else $error("decision taken twice for one patch");

endmodule

// ===== rtl/core/masked_patch_distance.sv =====
// top level of the masked patch distance block
//
//  channel   direction  handshake               payload
//  in        input      in_valid / in_ready     a_pixel b_pixel a_mask b_mask
//                                               center_flag cutoff last_flag
//  out       output     out_valid / out_ready   distance rejected
//  cfg       input      cfg_we (no wait)        cfg_index cfg_data
//
// one input word per cycle while a patch streams in; the squares are
// registered before accumulation
// after the last word the sequencer passes through the drain and decide states,
// then steps the bit-serial divider unless the patch is rejected, then loads the
// output register once it is free
// a waiting result does not hold up the next patch: the output register
// keeps it while the next patch streams in; only a finished patch waits
// async reset restores patch_width 7 and mask_limit 10 and clears all sums
module masked_patch_distance import mpd_pkg::*; #(
	parameter int MAX_PATCH_WIDTH = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration writes
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [MASK_W-1:0] cfg_data,
	// pixel pair words
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [PIX_W-1:0]  a_pixel,
	input  logic [PIX_W-1:0]  b_pixel,
	input  logic [MASK_W-1:0] a_mask,
	input  logic [MASK_W-1:0] b_mask,
	input  logic              center_flag,
	input  logic [PIX_W-1:0]  cutoff,
	input  logic              last_flag,
	// result words
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PIX_W-1:0]  distance,
	output logic              rejected
);

	// commands flow from the sequencer, status flows back
	cmd_t    cmd;
	status_t stat;

	// sequencer: accepts words, waits for the drain, runs the divider
	mpd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_last_flag (last_flag),
		.stat         (stat),
		.in_ready     (in_ready),
		.cmd          (cmd)
	);

	// datapath: squares, saturating sums, rejection test, divider
	mpd_dp #(
		.MAX_PATCH_WIDTH (MAX_PATCH_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.a_pixel     (a_pixel),
		.b_pixel     (b_pixel),
		.a_mask      (a_mask),
		.b_mask      (b_mask),
		.center_flag (center_flag),
		.cutoff      (cutoff),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.distance    (distance),
		.rejected    (rejected)
	);

endmodule
